// ===== sv/pcsp_pkg.sv =====
// shared types and constants for the prism cylinder support point unit
`default_nettype none
package pcsp_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegRadius     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHalfHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEdgeCount  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEdgePair0  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEdgePair4  = 3'd7;
  localparam int unsigned EdgeSlots = 10;
  localparam int unsigned PairCount = 5;
  localparam int unsigned MaskW = 22;

  // datapath step codes
  localparam logic [3:0] StepNone  = 4'd0;
  localparam logic [3:0] StepDots  = 4'd1;
  localparam logic [3:0] StepEdge  = 4'd2;
  localparam logic [3:0] StepFin   = 4'd3;
  localparam logic [3:0] StepScale = 4'd4;
  localparam logic [3:0] StepSum   = 4'd5;

  typedef struct packed {
    logic [15:0] side_x, side_y, side_z;
    logic [15:0] up_x, up_y, up_z;
    logic [15:0] depth_x, depth_y, depth_z;
    logic [23:0] dir_x, dir_y, dir_z;
  } in_item_t;

  typedef struct packed {
    logic [18:0] point_x, point_y, point_z;
    logic [MaskW-1:0] feature_mask;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;    // capture item
    logic [3:0] step;    // sequencing step code
    logic [3:0] edge_idx;
  } dp_cmd_t;
endpackage
`default_nettype wire

// ===== sv/pcsp_if.sv =====
// valid/ready channel interface
`default_nettype none
interface pcsp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/prism_cylinder_support_point_unit.sv =====
// top level of the prism cylinder support point unit
// Support mapping for a cylinder modeled as a prism. Each transaction takes a basis and a
// query direction and returns one support point (signed Q11.8) and a feature mask. After
// accept, an item runs through basis dot products, one edge dot and compare per edge on
// the single shared edge multiplier-compare unit, then point assembly (finish, scale, sum).
// A new item is accepted only once the previous result is taken. Configuration writes go
// to cfg index 0 radius, 1 half height, 2 number of edges (zero taken as a single edge, above
// MAX_EDGES clamped), 3..7 edge pairs.
`default_nettype none
module prism_cylinder_support_point_unit
  import pcsp_pkg::*;
#(
  parameter int unsigned MAX_EDGES = 10
)(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i,
  pcsp_if.sink                   in_if,
  pcsp_if.source                 out_if
);
  logic [15:0] radius_q, half_height_q;
  logic [3:0]  edge_count_q, n;
  logic [63:0] pair_q [PairCount];
  dp_cmd_t     cmd;

  // effective edge count
  always_comb begin
    n = edge_count_q;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MAX_EDGES)) n = 4'(MAX_EDGES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      half_height_q <= '0;
      edge_count_q <= 4'd1;
      for (int i = 0; i < PairCount; i++) pair_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRadius:     radius_q <= cfg_data_i[15:0];
        RegHalfHeight: half_height_q <= cfg_data_i[15:0];
        RegEdgeCount:  edge_count_q <= cfg_data_i[3:0];
        default: begin
          if (cfg_idx_i >= RegEdgePair0 && cfg_idx_i <= RegEdgePair4)
            pair_q[3'(cfg_idx_i - RegEdgePair0)] <= cfg_data_i;
        end
      endcase
    end
  end

  pcsp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .n_i        (n),
    .cmd_o      (cmd)
  );

  pcsp_dp u_dp (
    .clk_i,
    .cmd_i        (cmd),
    .in_i         (in_if.data),
    .radius_i     (radius_q),
    .half_height_i(half_height_q),
    .n_i          (n),
    .pair_i       (pair_q),
    .out_o        (out_if.data)
  );
endmodule
`default_nettype wire

// ===== sv/pcsp_ctrl.sv =====
// sequencing state machine
`default_nettype none
module pcsp_ctrl
  import pcsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire logic [3:0] n_i,
  output dp_cmd_t      cmd_o
);
  // steps: one basis dot step, one step per edge, then three point assembly steps
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDots = 2'd1;
  localparam logic [1:0] SEdge = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ov_q, ov_d;
  logic       fin_done;

  assign in_ready_o  = (state_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign fin_done    = (state_q == SFin) && (cnt_q == 4'd2);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    cmd_o.load = 1'b0;
    cmd_o.step = StepNone;
    cmd_o.edge_idx = cnt_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i && !ov_q) begin
          cmd_o.load = 1'b1;
          state_d = SDots;
          cnt_d = 4'd0;
        end
      end
      SDots: begin
        cmd_o.step = StepDots;
        cnt_d = 4'd0;
        state_d = SEdge;
      end
      SEdge: begin
        cmd_o.step = StepEdge;
        if (cnt_q == n_i - 4'd1) begin
          state_d = SFin;
          cnt_d = 4'd0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      SFin: begin
        cmd_o.step = StepFin + cnt_q;
        if (fin_done) begin
          state_d = SIdle;
          ov_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/pcsp_dp.sv =====
// datapath: dot products, edge search, point assembly
`default_nettype none
module pcsp_dp
  import pcsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire dp_cmd_t     cmd_i,
  input  wire in_item_t    in_i,
  input  wire logic [15:0] radius_i,
  input  wire logic [15:0] half_height_i,
  input  wire logic [3:0]  n_i,
  input  wire logic [63:0] pair_i [PairCount],
  output out_item_t        out_o
);
  in_item_t          it_q;
  logic signed [41:0] cx_q, cz_q;
  logic               top_q;
  logic signed [58:0] best_q;
  logic [3:0]         pick_q;
  logic signed [16:0] ex_q, ez_q;
  logic signed [33:0] rx_q, rz_q;
  logic signed [33:0] hh_q;
  logic [4:0]         face_q, next_q;
  logic signed [52:0] px_q, py_q, pz_q;

  logic signed [15:0] sx, sy, sz, ux, uy, uz, dx, dy, dz;
  logic signed [23:0] qx, qy, qz;
  logic signed [41:0] udot, cx_c, cz_c;
  logic [63:0]        pw;
  logic signed [15:0] ex_c, ez_c;
  logic signed [58:0] d_c, ad, ab;
  logic [4:0]         face_c;

  assign sx = it_q.side_x;  assign sy = it_q.side_y;  assign sz = it_q.side_z;
  assign ux = it_q.up_x;    assign uy = it_q.up_y;    assign uz = it_q.up_z;
  assign dx = it_q.depth_x; assign dy = it_q.depth_y; assign dz = it_q.depth_z;
  assign qx = it_q.dir_x;   assign qy = it_q.dir_y;   assign qz = it_q.dir_z;

  // three basis dots in one step, one narrow multiplier each term
  assign udot = 42'(ux * qx) + 42'(uy * qy) + 42'(uz * qz);
  assign cx_c = 42'(sx * qx) + 42'(sy * qy) + 42'(sz * qz);
  assign cz_c = 42'(dx * qx) + 42'(dy * qy) + 42'(dz * qz);

  // edge pick: index in search, pick_q in finish
  always_comb begin
    logic [3:0] ei;
    ei = (cmd_i.step == StepEdge) ? cmd_i.edge_idx : pick_q;
    pw = pair_i[3'(ei >> 1)];
    ex_c = ei[0] ? $signed(pw[47:32]) : $signed(pw[15:0]);
    ez_c = ei[0] ? $signed(pw[63:48]) : $signed(pw[31:16]);
  end
  assign d_c = 59'(cx_q * ex_c) + 59'(cz_q * ez_c);
  assign ad  = d_c[58] ? -d_c : d_c;
  assign ab  = best_q[58] ? -best_q : best_q;
  assign face_c = best_q[58] ? 5'(pick_q) + 5'(n_i) : 5'(pick_q);

  function automatic logic [18:0] to_q88(input logic signed [52:0] v);
    logic signed [52:0] r, q;
    r = v + 53'sd134217728;
    q = r >>> 28;
    if (q > 53'sd262143) return 19'h3FFFF;
    if (q < -53'sd262144) return 19'h40000;
    return q[18:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_i;
    case (cmd_i.step)
      StepDots: begin
        top_q <= udot > 0;
        cx_q <= cx_c;
        cz_q <= cz_c;
      end
      StepEdge: begin
        if (cmd_i.edge_idx == 4'd0 || ad > ab) begin
          best_q <= d_c;
          pick_q <= cmd_i.edge_idx;
        end
      end
      StepFin: begin
        ex_q <= best_q[58] ? -17'(ex_c) : 17'(ex_c);
        ez_q <= best_q[58] ? -17'(ez_c) : 17'(ez_c);
        face_q <= face_c;
        next_q <= (face_c == {n_i, 1'b0} - 5'd1) ? 5'd0 : face_c + 5'd1;
        hh_q <= top_q ? 34'(half_height_i) : -34'(half_height_i);
      end
      StepScale: begin
        rx_q <= 34'(ex_q * $signed({1'b0, radius_i}));
        rz_q <= 34'(ez_q * $signed({1'b0, radius_i}));
        hh_q <= hh_q <<< 14;
      end
      StepSum: begin
        px_q <= 53'(ux * hh_q) + 53'(sx * rx_q) + 53'(dx * rz_q);
        py_q <= 53'(uy * hh_q) + 53'(sy * rx_q) + 53'(dy * rz_q);
        pz_q <= 53'(uz * hh_q) + 53'(sz * rx_q) + 53'(dz * rz_q);
      end
      default: ;
    endcase
  end

  assign out_o.point_x = to_q88(px_q);
  assign out_o.point_y = to_q88(py_q);
  assign out_o.point_z = to_q88(pz_q);
  assign out_o.feature_mask = (top_q ? 22'h1 : 22'h2)
    | (22'h1 << (5'd2 + face_q)) | (22'h1 << (5'd2 + next_q));
endmodule
`default_nettype wire
